/* hw/rtl/pis_pkg.sv */
// shared types, reset values and saturation helpers for the particle step block
package pis_pkg;

    typedef enum logic [2:0] {
        CFG_FRAME_STEP  = 3'd0,
        CFG_GRAVITY_X   = 3'd1,
        CFG_GRAVITY_Y   = 3'd2,
        CFG_GRAVITY_Z   = 3'd3,
        CFG_DRAG_RATE   = 3'd4,
        CFG_START_COLOR = 3'd5,
        CFG_END_COLOR   = 3'd6
    } t_cfg_idx;

    localparam logic [30:0] FRAME_STEP_RST  = 31'd1092;
    localparam logic [31:0] GRAVITY_X_RST   = 32'h0000_0000;
    localparam logic [31:0] GRAVITY_Y_RST   = 32'hFFF6_3333;
    localparam logic [31:0] GRAVITY_Z_RST   = 32'h0000_0000;
    localparam logic [30:0] DRAG_RATE_RST   = 31'd0;
    localparam logic [31:0] START_COLOR_RST = 32'hFFFF_FFFF;
    localparam logic [31:0] END_COLOR_RST   = 32'h0000_0000;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      ang;
        logic [30:0]      age;
    } t_motion;

    typedef struct packed {
        logic [30:0] s0;
        logic [30:0] s1;
    } t_sizes;

    typedef struct packed {
        t_motion     mot;
        logic [30:0] size;
        logic [31:0] color;
        logic        dead;
    } t_result;

    function automatic logic [31:0] sat_s32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] sat_u31(input logic signed [63:0] x);
        logic [30:0] r;
        if (x > 64'sd2147483647) begin
            r = 31'h7FFF_FFFF;
        end else if (x < 64'sd0) begin
            r = 31'd0;
        end else begin
            r = x[30:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_u8(input logic signed [63:0] x);
        logic [7:0] r;
        if (x > 64'sd255) begin
            r = 8'hFF;
        end else if (x < 64'sd0) begin
            r = 8'h00;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sext64(input logic [31:0] v);
        return $signed({{32{v[31]}}, v});
    endfunction

endpackage

/* hw/rtl/pis_motion.sv */
// six-stage velocity, position, angle and age update
module pis_motion import pis_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2:0][31:0] i_pos,
    input  logic [2:0][31:0] i_vel,
    input  logic [31:0]      i_ang,
    input  logic [31:0]      i_spin,
    input  logic [30:0]      i_age,
    input  logic [30:0]      i_step,
    input  logic [2:0][31:0] i_grav,
    input  logic [30:0]      i_drag,
    output t_motion          o_mot
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // stage 1: products with the step
    logic signed [63:0] r1_gdt [3];
    logic [61:0]        r1_drag;
    logic signed [63:0] r1_spin;
    logic [2:0][31:0]   r1_vel;
    logic [2:0][31:0]   r1_pos;
    logic [31:0]        r1_ang;
    logic [30:0]        r1_age;
    logic [31:0]        n_age_sum;

    assign n_age_sum = {1'b0, i_age} + {1'b0, i_step};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_gdt[i] <= $signed(i_grav[i]) * $signed({1'b0, i_step});
            end
            r1_drag <= i_drag * i_step;
            r1_spin <= $signed(i_spin) * $signed({1'b0, i_step});
            r1_vel  <= i_vel;
            r1_pos  <= i_pos;
            r1_ang  <= i_ang;
            r1_age  <= n_age_sum[31] ? 31'h7FFF_FFFF : n_age_sum[30:0];
        end
    end

    // stage 2: add gravity, damping factor, angle
    logic [2:0][31:0] r2_v1;
    logic [31:0]      r2_damp;
    logic [2:0][31:0] r2_pos;
    logic [31:0]      r2_ang;
    logic [30:0]      r2_age;
    logic [2:0][31:0] n_v1;
    logic [31:0]      n_damp;
    logic [31:0]      n_ang;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_v1[i] = sat_s32(sext64(r1_vel[i]) + (r1_gdt[i] >>> FRAC_BITS));
        end
        n_damp = sat_s32(ONE - $signed({2'b00, r1_drag >> FRAC_BITS}));
        n_ang  = sat_s32(sext64(r1_ang) + (r1_spin >>> FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_v1   <= n_v1;
            r2_damp <= n_damp;
            r2_pos  <= r1_pos;
            r2_ang  <= n_ang;
            r2_age  <= r1_age;
        end
    end

    // stage 3: drag product
    logic signed [63:0] r3_prod [3];
    logic [2:0][31:0]   r3_pos;
    logic [31:0]        r3_ang;
    logic [30:0]        r3_age;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_prod[i] <= $signed(r2_v1[i]) * $signed(r2_damp);
            end
            r3_pos <= r2_pos;
            r3_ang <= r2_ang;
            r3_age <= r2_age;
        end
    end

    // stage 4: new velocity
    logic [2:0][31:0] r4_vel;
    logic [2:0][31:0] r4_pos;
    logic [31:0]      r4_ang;
    logic [30:0]      r4_age;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_vel[i] <= sat_s32(r3_prod[i] >>> FRAC_BITS);
            end
            r4_pos <= r3_pos;
            r4_ang <= r3_ang;
            r4_age <= r3_age;
        end
    end

    // stage 5: displacement product
    logic signed [63:0] r5_disp [3];
    logic [2:0][31:0]   r5_vel;
    logic [2:0][31:0]   r5_pos;
    logic [31:0]        r5_ang;
    logic [30:0]        r5_age;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_disp[i] <= $signed(r4_vel[i]) * $signed({1'b0, i_step});
            end
            r5_vel <= r4_vel;
            r5_pos <= r4_pos;
            r5_ang <= r4_ang;
            r5_age <= r4_age;
        end
    end

    // stage 6: new position
    t_motion r6_mot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_mot.pos[i] <= sat_s32(sext64(r5_pos[i]) + (r5_disp[i] >>> FRAC_BITS));
            end
            r6_mot.vel <= r5_vel;
            r6_mot.ang <= r5_ang;
            r6_mot.age <= r5_age;
        end
    end

    assign o_mot = r6_mot;

endmodule

/* hw/rtl/pis_div.sv */
// pipelined restoring divider for the life fraction, one quotient bit a stage
module pis_div import pis_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [30:0]        i_num,
    input  logic [30:0]        i_den,
    input  t_sizes             i_side,
    output logic [FRAC_BITS:0] o_t,
    output logic               o_dead,
    output t_sizes             o_side
);

    localparam logic [FRAC_BITS:0] ONE_T = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [30:0]          r_rem  [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_q    [FRAC_BITS];
    logic [30:0]          r_den  [FRAC_BITS];
    logic                 r_dead [FRAC_BITS];
    t_sizes               r_side [FRAC_BITS];

    logic [30:0]          s_rem  [FRAC_BITS];
    logic [FRAC_BITS-1:0] s_q    [FRAC_BITS];
    logic [30:0]          s_den  [FRAC_BITS];
    logic                 s_dead [FRAC_BITS];
    t_sizes               s_side [FRAC_BITS];

    logic [30:0]          n_rem  [FRAC_BITS];
    logic [FRAC_BITS-1:0] n_q    [FRAC_BITS];
    logic [31:0]          shifted;
    logic [31:0]          diff;
    logic                 dead0;

    assign dead0 = (i_den == 31'd0) || (i_num >= i_den);

    always_comb begin
        s_rem[0]  = dead0 ? 31'd0 : i_num;
        s_q[0]    = '0;
        s_den[0]  = i_den;
        s_dead[0] = dead0;
        s_side[0] = i_side;
        for (int k = 1; k < FRAC_BITS; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_q[k]    = r_q[k-1];
            s_den[k]  = r_den[k-1];
            s_dead[k] = r_dead[k-1];
            s_side[k] = r_side[k-1];
        end
    end

    // the remainder stays below the divisor, so the doubled value fits 32 bits
    always_comb begin
        shifted = '0;
        diff    = '0;
        for (int k = 0; k < FRAC_BITS; k++) begin
            shifted = {s_rem[k], 1'b0};
            diff    = shifted - {1'b0, s_den[k]};
            if (shifted >= {1'b0, s_den[k]}) begin
                n_rem[k] = diff[30:0];
                n_q[k]   = {s_q[k][FRAC_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = shifted[30:0];
                n_q[k]   = {s_q[k][FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < FRAC_BITS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_den[k]  <= s_den[k];
                r_dead[k] <= s_dead[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_t    = r_dead[FRAC_BITS-1] ? ONE_T : {1'b0, r_q[FRAC_BITS-1]};
    assign o_dead = r_dead[FRAC_BITS-1];
    assign o_side = r_side[FRAC_BITS-1];

endmodule

/* hw/rtl/pis_blend.sv */
// two-stage size and colour blend by the life fraction
module pis_blend import pis_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [FRAC_BITS:0] i_t,
    input  t_sizes             i_side,
    input  logic               i_dead,
    input  logic [31:0]        i_c0,
    input  logic [31:0]        i_c1,
    output logic [30:0]        o_size,
    output logic [31:0]        o_color,
    output logic               o_dead
);

    localparam int CW = FRAC_BITS + 11;

    logic signed [31:0]          n_sdiff;
    logic signed [FRAC_BITS+1:0] n_ts;
    logic signed [8:0]           n_cdiff [4];

    logic signed [63:0]   r_sprod;
    logic signed [CW-1:0] r_cprod [4];
    logic [30:0]          r_s0;
    logic                 r_dead1;

    always_comb begin
        n_ts    = $signed({1'b0, i_t});
        n_sdiff = $signed({1'b0, i_side.s1}) - $signed({1'b0, i_side.s0});
        for (int i = 0; i < 4; i++) begin
            n_cdiff[i] = $signed({1'b0, i_c1[8*i +: 8]}) - $signed({1'b0, i_c0[8*i +: 8]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sprod <= n_sdiff * n_ts;
            for (int i = 0; i < 4; i++) begin
                r_cprod[i] <= n_cdiff[i] * n_ts;
            end
            r_s0    <= i_side.s0;
            r_dead1 <= i_dead;
        end
    end

    logic signed [63:0] n_cext [4];
    logic [31:0]        n_color;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_cext[i] = 64'(r_cprod[i]);
            n_color[8*i +: 8] = clamp_u8($signed({56'd0, i_c0[8*i +: 8]})
                                         + (n_cext[i] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_size  <= sat_u31($signed({33'd0, r_s0}) + (r_sprod >>> FRAC_BITS));
            o_color <= n_color;
            o_dead  <= r_dead1;
        end
    end

endmodule

/* hw/rtl/particle_integrate_step.sv */
// particle step: stage 0, life fraction divider, blend stages to output register (Q16.16)
// throughput one word per cycle when the skid is empty; depth from the one-bit-a-stage divider
// a one-word skid register on the output keeps input ready independent of output ready
// synchronous active-low reset clears valid bits and loads the register reset values
// configuration writes are taken on any cycle; unknown indexes are ignored
module particle_integrate_step import pis_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [31:0] i_angle,
    input  logic [31:0] i_spin,
    input  logic [30:0] i_age,
    input  logic [30:0] i_lifespan,
    input  logic [30:0] i_size_begin,
    input  logic [30:0] i_size_finish,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_new_pos_x,
    output logic [31:0] o_new_pos_y,
    output logic [31:0] o_new_pos_z,
    output logic [31:0] o_new_vel_x,
    output logic [31:0] o_new_vel_y,
    output logic [31:0] o_new_vel_z,
    output logic [31:0] o_new_angle,
    output logic [30:0] o_new_age,
    output logic [30:0] o_cur_size,
    output logic [31:0] o_cur_color,
    output logic        o_is_dead
);

    localparam int LAT = FRAC_BITS + 3;
    localparam int DM  = FRAC_BITS - 3;

    // configuration registers
    logic [30:0]      r_step;
    logic [2:0][31:0] r_grav;
    logic [30:0]      r_drag;
    logic [31:0]      r_c0;
    logic [31:0]      r_c1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= FRAME_STEP_RST;
            r_grav[0] <= GRAVITY_X_RST;
            r_grav[1] <= GRAVITY_Y_RST;
            r_grav[2] <= GRAVITY_Z_RST;
            r_drag    <= DRAG_RATE_RST;
            r_c0      <= START_COLOR_RST;
            r_c1      <= END_COLOR_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_STEP:  r_step    <= i_cfg_data[30:0];
                CFG_GRAVITY_X:   r_grav[0] <= i_cfg_data;
                CFG_GRAVITY_Y:   r_grav[1] <= i_cfg_data;
                CFG_GRAVITY_Z:   r_grav[2] <= i_cfg_data;
                CFG_DRAG_RATE:   r_drag    <= i_cfg_data[30:0];
                CFG_START_COLOR: r_c0      <= i_cfg_data;
                CFG_END_COLOR:   r_c1      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: whole pipe advances unless the skid register is holding a word
    logic           en;
    logic [LAT-1:0] r_vld;
    logic           r_sk_v;
    t_result        r_sk;
    t_result        res;

    assign en         = !r_sk_v;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // stage 0: new age and the divider operands
    logic [31:0] n_age_sum;
    logic [30:0] r0_age;
    logic [30:0] r0_life;
    t_sizes      r0_sizes;

    assign n_age_sum = {1'b0, i_age} + {1'b0, r_step};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_age      <= n_age_sum[31] ? 31'h7FFF_FFFF : n_age_sum[30:0];
            r0_life     <= i_lifespan;
            r0_sizes.s0 <= i_size_begin;
            r0_sizes.s1 <= i_size_finish;
        end
    end

    // motion path
    t_motion mot6;

    pis_motion #(.FRAC_BITS(FRAC_BITS)) u_motion (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_pos  ({i_pos_z, i_pos_y, i_pos_x}),
        .i_vel  ({i_vel_z, i_vel_y, i_vel_x}),
        .i_ang  (i_angle),
        .i_spin (i_spin),
        .i_age  (i_age),
        .i_step (r_step),
        .i_grav (r_grav),
        .i_drag (r_drag),
        .o_mot  (mot6)
    );

    // line up the motion results with the blend output
    t_motion r_dly [DM];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= mot6;
            for (int k = 1; k < DM; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // life fraction and blends
    logic [FRAC_BITS:0] t_frac;
    logic               div_dead;
    t_sizes             div_side;

    pis_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r0_age),
        .i_den  (r0_life),
        .i_side (r0_sizes),
        .o_t    (t_frac),
        .o_dead (div_dead),
        .o_side (div_side)
    );

    logic [30:0] bl_size;
    logic [31:0] bl_color;
    logic        bl_dead;

    pis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_t     (t_frac),
        .i_side  (div_side),
        .i_dead  (div_dead),
        .i_c0    (r_c0),
        .i_c1    (r_c1),
        .o_size  (bl_size),
        .o_color (bl_color),
        .o_dead  (bl_dead)
    );

    assign res.mot   = r_dly[DM-1];
    assign res.size  = bl_size;
    assign res.color = bl_color;
    assign res.dead  = bl_dead;

    // output skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (i_out_ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (r_vld[LAT-1] && !i_out_ready) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) begin
            r_sk <= res;
        end
    end

    t_result out_w;

    assign out_w       = r_sk_v ? r_sk : res;
    assign o_out_valid = r_sk_v || r_vld[LAT-1];
    assign o_new_pos_x = out_w.mot.pos[0];
    assign o_new_pos_y = out_w.mot.pos[1];
    assign o_new_pos_z = out_w.mot.pos[2];
    assign o_new_vel_x = out_w.mot.vel[0];
    assign o_new_vel_y = out_w.mot.vel[1];
    assign o_new_vel_z = out_w.mot.vel[2];
    assign o_new_angle = out_w.mot.ang;
    assign o_new_age   = out_w.mot.age;
    assign o_cur_size  = out_w.size;
    assign o_cur_color = out_w.color;
    assign o_is_dead   = out_w.dead;

endmodule

/* dv/tb_top.sv */
// testbench for the particle step block: directed and random records checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import pis_pkg::*;

    typedef struct {
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic [31:0] ang;
        logic [31:0] spin;
        logic [30:0] age;
        logic [30:0] life;
        logic [30:0] s0;
        logic [30:0] s1;
    } t_particle;

    typedef struct {
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic [31:0] ang;
        logic [30:0] age;
        logic [30:0] size;
        logic [31:0] color;
        logic        dead;
    } t_update;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_pos_x, i_pos_y, i_pos_z, i_vel_x, i_vel_y, i_vel_z, i_angle, i_spin;
    logic [30:0] i_age, i_lifespan, i_size_begin, i_size_finish;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z, o_new_angle, o_cur_color;
    logic [30:0] o_new_age, o_cur_size;
    logic        o_is_dead;

    // predictor copy of the register file
    logic [30:0] step_q;
    logic signed [63:0] grav_q [3];
    logic [30:0] drag_q;
    logic [31:0] col_start_q, col_end_q;

    t_update     pending_updates [$];
    int          n_errors = 0;
    bit          out_stall_on = 1'b1;
    int          out_wait = 0;

    particle_integrate_step uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("particle_integrate_step test failed");
        $finish;
    end

    function automatic logic signed [63:0] fx_mul_floor(logic signed [63:0] a,
                                                        logic signed [63:0] b);
        return (a * b) >>> 16;
    endfunction

    function automatic logic signed [63:0] clip_s32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic signed [63:0] clip_u31(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < 0) return 0;
        return x;
    endfunction

    function automatic t_update advance_particle(t_particle p);
        t_update u;
        logic signed [63:0] dt, damp, v1, v, age, life, t, c, w;
        logic [63:0] num;
        dt   = $signed({33'd0, step_q});
        age  = clip_u31($signed({33'd0, p.age}) + dt);
        life = $signed({33'd0, p.life});
        damp = clip_s32(64'sd65536 - fx_mul_floor($signed({33'd0, drag_q}), dt));
        for (int i = 0; i < 3; i++) begin
            v1 = clip_s32($signed({{32{p.vel[i][31]}}, p.vel[i]}) + fx_mul_floor(grav_q[i], dt));
            v  = clip_s32(fx_mul_floor(v1, damp));
            u.vel[i] = v[31:0];
            w = clip_s32($signed({{32{p.pos[i][31]}}, p.pos[i]}) + fx_mul_floor(v, dt));
            u.pos[i] = w[31:0];
        end
        w = clip_s32($signed({{32{p.ang[31]}}, p.ang})
                     + fx_mul_floor($signed({{32{p.spin[31]}}, p.spin}), dt));
        u.ang  = w[31:0];
        u.age  = age[30:0];
        u.dead = (life == 0) || (age >= life);
        if (u.dead) begin
            t = 64'sd65536;
        end else begin
            num = age << 16;
            t = $signed(num / life);
        end
        w = clip_u31($signed({33'd0, p.s0})
                     + fx_mul_floor($signed({33'd0, p.s1}) - $signed({33'd0, p.s0}), t));
        u.size = w[30:0];
        for (int i = 0; i < 4; i++) begin
            c = $signed({56'd0, col_start_q[8*i +: 8]})
                + fx_mul_floor($signed({56'd0, col_end_q[8*i +: 8]})
                               - $signed({56'd0, col_start_q[8*i +: 8]}), t);
            if (c < 0) c = 0;
            if (c > 255) c = 255;
            u.color[8*i +: 8] = c[7:0];
        end
        return u;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        case (idx)
            CFG_FRAME_STEP:  step_q = data[30:0];
            CFG_GRAVITY_X:   grav_q[0] = $signed({{32{data[31]}}, data});
            CFG_GRAVITY_Y:   grav_q[1] = $signed({{32{data[31]}}, data});
            CFG_GRAVITY_Z:   grav_q[2] = $signed({{32{data[31]}}, data});
            CFG_DRAG_RATE:   drag_q = data[30:0];
            CFG_START_COLOR: col_start_q = data;
            CFG_END_COLOR:   col_end_q = data;
            default: ;
        endcase
    endtask

    // one word on the input channel; the gap comes first so valid holds across back-to-back words
    task automatic send_particle(t_particle p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        {i_pos_x, i_pos_y, i_pos_z} = {p.pos[0], p.pos[1], p.pos[2]};
        {i_vel_x, i_vel_y, i_vel_z} = {p.vel[0], p.vel[1], p.vel[2]};
        i_angle = p.ang;
        i_spin = p.spin;
        i_age = p.age;
        i_lifespan = p.life;
        i_size_begin = p.s0;
        i_size_finish = p.s1;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_updates.push_back(advance_particle(p));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_updates.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_s32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2000000) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rnd_u31();
        case ($urandom_range(0, 4))
            0: return 31'h7FFF_FFFF;
            1: return 31'd0;
            2: return 31'($urandom_range(0, 1000000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic t_particle rnd_particle();
        t_particle p;
        for (int i = 0; i < 3; i++) begin
            p.pos[i] = rnd_s32();
            p.vel[i] = rnd_s32();
        end
        p.ang  = rnd_s32();
        p.spin = rnd_s32();
        p.s0   = rnd_u31();
        p.s1   = rnd_u31();
        p.life = rnd_u31();
        // most particles mid-life so the blend fraction is exercised
        if ($urandom_range(0, 2) != 0 && p.life != 0) p.age = 31'($urandom_range(0, p.life));
        else p.age = rnd_u31();
        return p;
    endfunction

    task automatic test_directed();
        t_particle p;
        for (int k = 0; k < 20; k++) begin
            p = rnd_particle();
            case (k)
                0: begin p.life = 0; p.age = 0; end
                1: begin p.life = 31'h7FFF_FFFF; p.age = 31'h7FFF_FFFF; end
                2: begin p.life = 31'd65536; p.age = 0; end
                3: begin p.life = 31'h7FFF_FFFF; p.age = 0; p.s0 = 31'h7FFF_FFFF; p.s1 = 0; end
                4: begin p.s0 = 0; p.s1 = 31'h7FFF_FFFF; p.life = 31'd200000; p.age = 31'd1000; end
                5: for (int i = 0; i < 3; i++) begin
                        p.pos[i] = 32'h7FFF_FFFF; p.vel[i] = 32'h7FFF_FFFF;
                    end
                6: for (int i = 0; i < 3; i++) begin
                        p.pos[i] = 32'h8000_0000; p.vel[i] = 32'h8000_0000;
                    end
                7: begin p.ang = 32'h7FFF_FFFF; p.spin = 32'h7FFF_FFFF; end
                8: begin p.ang = 32'h8000_0000; p.spin = 32'h8000_0000; end
                9: begin p.age = 31'h7FFF_FFFF; p.life = 31'h7FFF_FFFE; end
                default: ;
            endcase
            send_particle(p);
        end
        drain();
    endtask

    task automatic test_random_phase(int n);
        for (int k = 0; k < n; k++) send_particle(rnd_particle());
        drain();
    endtask

    task automatic test_config_sweep();
        // extremes: big step, strong drag (negative damping), saturating gravity
        write_reg(CFG_FRAME_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_GRAVITY_X, 32'h7FFF_FFFF);
        write_reg(CFG_GRAVITY_Y, 32'h8000_0000);
        write_reg(CFG_GRAVITY_Z, 32'hFFFF_FFFF);
        write_reg(CFG_DRAG_RATE, 32'h7FFF_FFFF);
        write_reg(CFG_START_COLOR, 32'h00FF_00FF);
        write_reg(CFG_END_COLOR, 32'hFF00_FF00);
        test_random_phase(150);
        write_reg(CFG_FRAME_STEP, 32'd0);
        write_reg(CFG_DRAG_RATE, 32'd0);
        test_random_phase(100);
        // strong drag past one step
        write_reg(CFG_FRAME_STEP, 32'd65536);
        write_reg(CFG_DRAG_RATE, 32'd200000);
        write_reg(CFG_GRAVITY_X, 32'h8000_0000);
        write_reg(CFG_START_COLOR, 32'h0000_0000);
        write_reg(CFG_END_COLOR, 32'hFFFF_FFFF);
        test_random_phase(150);
        for (int r = 0; r < 4; r++) begin
            write_reg(CFG_FRAME_STEP, $urandom_range(0, 200000));
            write_reg(CFG_GRAVITY_X, rnd_s32());
            write_reg(CFG_GRAVITY_Y, rnd_s32());
            write_reg(CFG_GRAVITY_Z, rnd_s32());
            write_reg(CFG_DRAG_RATE, $urandom_range(0, 131072));
            write_reg(CFG_START_COLOR, $urandom);
            write_reg(CFG_END_COLOR, $urandom);
            test_random_phase(110);
        end
    endtask

    // output side: stalls of random length, with the odd stretch of none
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) out_stall_on <= ~out_stall_on;
        if (out_wait > 0) begin
            out_wait    <= out_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (out_stall_on) out_wait <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_update e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected result word", $realtime);
                n_errors++;
            end else begin
                e = pending_updates.pop_front();
                if ({o_new_pos_x, o_new_pos_y, o_new_pos_z, o_new_vel_x, o_new_vel_y,
                     o_new_vel_z, o_new_angle, o_new_age, o_cur_size, o_cur_color, o_is_dead}
                    !== {e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2],
                         e.ang, e.age, e.size, e.color, e.dead}) begin
                    $display("%0t: mismatch exp pos %h %h %h vel %h %h %h ang %h age %h size %h col %h dead %b",
                             $realtime, e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2],
                             e.ang, e.age, e.size, e.color, e.dead);
                    $display("%0t:          got pos %h %h %h vel %h %h %h ang %h age %h size %h col %h dead %b",
                             $realtime, o_new_pos_x, o_new_pos_y, o_new_pos_z, o_new_vel_x,
                             o_new_vel_y, o_new_vel_z, o_new_angle, o_new_age, o_cur_size,
                             o_cur_color, o_is_dead);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FRAME_STEP;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        {i_pos_x, i_pos_y, i_pos_z, i_vel_x, i_vel_y, i_vel_z, i_angle, i_spin} = '0;
        {i_age, i_lifespan, i_size_begin, i_size_finish} = '0;
        step_q = FRAME_STEP_RST;
        grav_q[0] = sext64(GRAVITY_X_RST);
        grav_q[1] = sext64(GRAVITY_Y_RST);
        grav_q[2] = sext64(GRAVITY_Z_RST);
        drag_q = DRAG_RATE_RST;
        col_start_q = START_COLOR_RST;
        col_end_q = END_COLOR_RST;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_phase(190);
        test_config_sweep();
        if (n_errors == 0) begin
            $display("particle_integrate_step test passed");
        end else begin
            $display("particle_integrate_step test failed");
        end
        $finish;
    end

endmodule
